// ===== rtl/fpfd_pkg.sv =====
// Package for the fixed packet frame deframer.
// Holds widths, register indexes, header constants and shared struct types.
// No dependencies.
`timescale 1ns / 1ps

package fpfd_pkg;

  // Width of the in-packet byte position counter
  localparam int POSITION_WIDTH = 16;
  // Effective packet length can reach 2^POSITION_WIDTH, so one extra bit
  localparam int LEN_W = POSITION_WIDTH + 1;
  // Compare width for clamping the 16-bit register against the cap
  localparam int CLAMP_W = (LEN_W > 16) ? LEN_W : 16;

  // Configuration register widths and reset values
  localparam int PKT_LEN_W = 16;
  localparam int TYPE_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam logic [PKT_LEN_W-1:0] PKT_LEN_RESET = 16'd1140;
  localparam logic [TYPE_W-1:0] START_TYPE_RESET = 8'd1;
  localparam logic [PKT_LEN_W-1:0] MIN_PKT_LEN = 16'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TYPE = 8'd1;

  // Start packet header: type byte plus 4 length bytes
  localparam logic [POSITION_WIDTH-1:0] HEADER_BYTES = POSITION_WIDTH'(5);

  // Frame length / emitted count width
  localparam int FLEN_W = 32;

  // Active configuration as seen by the datapath
  typedef struct packed {
    logic [LEN_W-1:0]  eff_len;
    logic [TYPE_W-1:0] start_type;
  } fpfd_cfg_t;

  // One result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       prior_cut;
  } fpfd_result_t;

endpackage

// ===== rtl/fixed_packet_frame_deframer_top.sv =====
// Top level of the fixed packet frame deframer.
// Depends on fpfd_pkg, fpfd_cfg, fpfd_core and fpfd_out.
//
//   channel   ports                         role
//   input     in_valid/in_ready, in_*       raw packet stream bytes
//   result    out_valid/out_ready, out_*    frame payload bytes with marks
//   config    cfg_we, cfg_index, cfg_data   packet_length (0), start_type (1)
//
// One byte per cycle sustained while the output is not stalled; a payload byte
// passes the input reg and then the output reg before it can leave.
// Header, discarded and surplus bytes give no result word.
// Reset is synchronous on rst_n; all frame state and both stages are cleared.
// A stalled output holds its word and freezes the input register, so at most
// one more byte is taken and in_ready stays low until the word leaves.
`timescale 1ns / 1ps

module fixed_packet_frame_deframer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_first_of_frame,
  output logic                            out_last_of_frame,
  output logic                            out_prior_cut,
  input  logic                            cfg_we,
  input  logic [fpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  fpfd_pkg::fpfd_cfg_t    cfg;
  fpfd_pkg::fpfd_result_t res_core;
  fpfd_pkg::fpfd_result_t res_out;
  logic                   res_load;
  logic                   res_free;

  fpfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  fpfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .res_free     (res_free),
    .res_load     (res_load),
    .res_o        (res_core)
  );

  fpfd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_i     (res_core),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_out)
  );

  assign out_payload_byte   = res_out.payload_byte;
  assign out_first_of_frame = res_out.first_of_frame;
  assign out_last_of_frame  = res_out.last_of_frame;
  assign out_prior_cut      = res_out.prior_cut;

endmodule

// ===== rtl/fpfd_cfg.sv =====
// Configuration registers of the deframer and the clamped packet length.
// Depends on fpfd_pkg.
`timescale 1ns / 1ps

module fpfd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output fpfd_pkg::fpfd_cfg_t            cfg_o
);

  logic [fpfd_pkg::PKT_LEN_W-1:0] pkt_len_r, pkt_len_nxt;
  logic [fpfd_pkg::TYPE_W-1:0]    start_type_r, start_type_nxt;
  logic [fpfd_pkg::CLAMP_W-1:0]   len_wide;
  logic [fpfd_pkg::CLAMP_W-1:0]   cap_wide;

  // Register writes
  always_comb begin
    pkt_len_nxt    = pkt_len_r;
    start_type_nxt = start_type_r;
    if (cfg_we) begin
      if (cfg_index == fpfd_pkg::REG_PACKET_LENGTH) begin
        pkt_len_nxt = cfg_data[fpfd_pkg::PKT_LEN_W-1:0];
      end else if (cfg_index == fpfd_pkg::REG_START_TYPE) begin
        start_type_nxt = cfg_data[fpfd_pkg::TYPE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_len_r    <= fpfd_pkg::PKT_LEN_RESET;
      start_type_r <= fpfd_pkg::START_TYPE_RESET;
    end else begin
      pkt_len_r    <= pkt_len_nxt;
      start_type_r <= start_type_nxt;
    end
  end

  // Clamp length to [6, 2^POSITION_WIDTH]
  always_comb begin
    cap_wide = fpfd_pkg::CLAMP_W'(1) << fpfd_pkg::POSITION_WIDTH;
    if (pkt_len_r < fpfd_pkg::MIN_PKT_LEN) begin
      len_wide = fpfd_pkg::CLAMP_W'(fpfd_pkg::MIN_PKT_LEN);
    end else begin
      len_wide = fpfd_pkg::CLAMP_W'(pkt_len_r);
    end
    if (len_wide > cap_wide) begin
      len_wide = cap_wide;
    end
    cfg_o.eff_len    = len_wide[fpfd_pkg::LEN_W-1:0];
    cfg_o.start_type = start_type_r;
  end

endmodule

// ===== rtl/fpfd_core.sv =====
// Input register, frame state and per-byte decode of the deframer.
// Depends on fpfd_pkg.
`timescale 1ns / 1ps

module fpfd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpfd_pkg::fpfd_cfg_t       cfg_i,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      res_free,
  output logic                      res_load,
  output fpfd_pkg::fpfd_result_t    res_o
);

  localparam int PW = fpfd_pkg::POSITION_WIDTH;
  localparam int FW = fpfd_pkg::FLEN_W;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 synced_r, synced_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 in_start_r, in_start_nxt;
  logic [FW-1:0]        flen_r, flen_nxt;
  logic [FW-1:0]        emitted_r, emitted_nxt;
  logic                 pending_r, pending_nxt;

  logic                 fire;
  logic                 is_start;
  logic                 more_left;
  logic                 emit;
  logic                 first;
  logic                 last;
  logic [fpfd_pkg::LEN_W-1:0] pos_inc;

  // Input register advances whenever the result stage can take a word
  assign fire     = s1_valid_r && res_free;
  assign in_ready = !s1_valid_r || res_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // Per-byte decode
  assign is_start  = (s1_byte_r == cfg_i.start_type);
  assign more_left = (emitted_r < flen_r);
  assign first     = (emitted_r == '0);
  assign last      = ({1'b0, emitted_r} + (FW+1)'(1)) == {1'b0, flen_r};
  assign pos_inc   = fpfd_pkg::LEN_W'(pos_r) + fpfd_pkg::LEN_W'(1);

  always_comb begin
    synced_nxt   = synced_r;
    in_start_nxt = in_start_r;
    flen_nxt     = flen_r;
    emitted_nxt  = emitted_r;
    pending_nxt  = pending_r;
    pos_nxt      = pos_r;
    emit         = 1'b0;
    if (fire) begin
      if (pos_r == '0) begin
        if (is_start) begin
          if (synced_r && more_left) begin
            pending_nxt = 1'b1;
          end
          synced_nxt   = 1'b1;
          in_start_nxt = 1'b1;
          flen_nxt     = '0;
          emitted_nxt  = '0;
        end else begin
          in_start_nxt = 1'b0;
        end
      end else if (synced_r) begin
        if (in_start_r && (pos_r < fpfd_pkg::HEADER_BYTES)) begin
          // big-endian length byte
          flen_nxt = {flen_r[FW-9:0], s1_byte_r};
        end else if (more_left) begin
          emit        = 1'b1;
          emitted_nxt = emitted_r + FW'(1);
          if (first) begin
            pending_nxt = 1'b0;
          end
        end
      end
      // position wraps at the effective packet length
      if (pos_inc >= cfg_i.eff_len) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r   <= 1'b0;
      in_start_r <= 1'b0;
      flen_r     <= '0;
      emitted_r  <= '0;
      pending_r  <= 1'b0;
      pos_r      <= '0;
    end else begin
      synced_r   <= synced_nxt;
      in_start_r <= in_start_nxt;
      flen_r     <= flen_nxt;
      emitted_r  <= emitted_nxt;
      pending_r  <= pending_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Result word toward the output register
  assign res_load             = emit;
  assign res_o.payload_byte   = s1_byte_r;
  assign res_o.first_of_frame = first;
  assign res_o.last_of_frame  = last;
  assign res_o.prior_cut      = first && pending_r;

`ifndef ASSERT_OFF
  // emitted count never runs past the declared length
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r <= flen_r)
    else $error("bytes emitted exceed frame length");

  // nothing is counted before the first start packet
  a_unsynced_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !synced_r |-> (flen_r == '0) && (emitted_r == '0))
    else $error("frame state moved before sync");

  // a start type byte at packet position zero opens a fresh frame
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (pos_r == '0) && is_start |=> synced_r && in_start_r && (emitted_r == '0))
    else $error("start packet did not open a frame");
`endif

endmodule

// ===== rtl/fpfd_out.sv =====
// Output register of the deframer: holds one result word until taken.
// Depends on fpfd_pkg.
`timescale 1ns / 1ps

module fpfd_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  fpfd_pkg::fpfd_result_t res_i,
  output logic                   res_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fpfd_pkg::fpfd_result_t res_o
);

  logic                   out_valid_r, out_valid_nxt;
  fpfd_pkg::fpfd_result_t res_r;

  // Free when empty or being drained this cycle
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_i;
    end
  end

  assign out_valid = out_valid_r;
  assign res_o     = res_r;

endmodule

// ===== tb/sv/fpfd_deframer_checker.sv =====
// Scoreboard for the fixed packet frame deframer: watches the input, result and
// register ports, predicts each payload word and compares it field by field.
// Depends on fpfd_pkg.
`timescale 1ns / 1ps

module fpfd_deframer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      out_payload_byte,
  input  logic                            out_first_of_frame,
  input  logic                            out_last_of_frame,
  input  logic                            out_prior_cut,
  input  logic                            cfg_we,
  input  logic [fpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              words_outstanding
);

  // register copies
  logic [fpfd_pkg::PKT_LEN_W-1:0] pkt_len_reg;
  logic [fpfd_pkg::TYPE_W-1:0]    start_type_reg;

  // deframer state
  logic                        synced;
  logic                        in_start_pkt;
  logic                        cut_pending;
  longint unsigned             position;
  logic [fpfd_pkg::FLEN_W-1:0] frame_len;
  logic [fpfd_pkg::FLEN_W-1:0] emitted;

  fpfd_pkg::fpfd_result_t      expected_words[$];
  int                          mismatch_count = 0;
  int                          pending_count = 0;

  assign mismatches = mismatch_count;
  assign words_outstanding = pending_count;

  // packet length as the datapath uses it: floor of 6, cap of 2^POSITION_WIDTH
  function automatic longint unsigned eff_packet_len();
    longint unsigned len;
    longint unsigned cap;
    len = pkt_len_reg;
    cap = longint'(1) << fpfd_pkg::POSITION_WIDTH;
    if (len < fpfd_pkg::MIN_PKT_LEN) len = fpfd_pkg::MIN_PKT_LEN;
    if (len > cap) len = cap;
    return len;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] deframer mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  // one accepted byte: update frame state, queue the payload word it yields
  task automatic deframe_byte(input logic [7:0] b);
    fpfd_pkg::fpfd_result_t w;
    longint unsigned        len;
    logic                   first;
    len = eff_packet_len();
    if (position == 0) begin
      if (b == start_type_reg) begin
        if (synced && emitted < frame_len) cut_pending = 1'b1;
        synced = 1'b1;
        in_start_pkt = 1'b1;
        frame_len = '0;
        emitted = '0;
      end else begin
        in_start_pkt = 1'b0;
      end
    end else if (synced) begin
      if (in_start_pkt && position < fpfd_pkg::HEADER_BYTES) begin
        frame_len = {frame_len[fpfd_pkg::FLEN_W-9:0], b};
      end else if (emitted < frame_len) begin
        first = (emitted == 0);
        w.payload_byte = b;
        w.first_of_frame = first;
        w.last_of_frame = ({1'b0, emitted} + 33'd1 == {1'b0, frame_len});
        w.prior_cut = first && cut_pending;
        if (first) cut_pending = 1'b0;
        emitted = emitted + 1;
        expected_words.push_back(w);
      end
    end
    position = (position + 1 >= len) ? 0 : position + 1;
  endtask

  always @(posedge clk) begin
    fpfd_pkg::fpfd_result_t want;
    if (!rst_n) begin
      pkt_len_reg = fpfd_pkg::PKT_LEN_RESET;
      start_type_reg = fpfd_pkg::START_TYPE_RESET;
      synced = 1'b0;
      in_start_pkt = 1'b0;
      cut_pending = 1'b0;
      position = 0;
      frame_len = '0;
      emitted = '0;
      expected_words.delete();
    end else begin
      // result side first: a word never leaves in the cycle its byte enters
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0h with none expected", out_payload_byte));
        end else begin
          want = expected_words.pop_front();
          check_field("payload_byte", out_payload_byte, want.payload_byte);
          check_field("first_of_frame", out_first_of_frame, want.first_of_frame);
          check_field("last_of_frame", out_last_of_frame, want.last_of_frame);
          check_field("prior_cut", out_prior_cut, want.prior_cut);
        end
      end
      if (in_valid && in_ready) deframe_byte(in_data_byte);
      if (cfg_we) begin
        if (cfg_index == fpfd_pkg::REG_PACKET_LENGTH)
          pkt_len_reg = cfg_data[fpfd_pkg::PKT_LEN_W-1:0];
        else if (cfg_index == fpfd_pkg::REG_START_TYPE)
          start_type_reg = cfg_data[fpfd_pkg::TYPE_W-1:0];
      end
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== tb/sv/fixed_packet_frame_deframer_top_tb.sv =====
// Testbench top for the fixed packet frame deframer: clock, reset, byte
// stimulus with random idling and the verdict.
// Depends on fpfd_pkg, fpfd_deframer_checker and the deframer RTL.
`timescale 1ns / 1ps

module fixed_packet_frame_deframer_top_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_WORDS = 100;
  localparam int CYCLE_LIMIT = 400000;
  // index past the last register, writes to it must be ignored
  localparam logic [fpfd_pkg::CFG_IDX_W-1:0] REG_NONE = 8'd2;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      in_data_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic [7:0]                      out_payload_byte;
  logic                            out_first_of_frame;
  logic                            out_last_of_frame;
  logic                            out_prior_cut;
  logic                            cfg_we;
  logic [fpfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fpfd_pkg::CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    words_outstanding;
  int                    cycle_count = 0;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  bit                    hold_req = 1'b0;
  bit                    hold_taken = 1'b0;

  // stimulus-side view of the stream alignment
  int unsigned           tb_pkt_len = fpfd_pkg::PKT_LEN_RESET;
  int unsigned           tb_pos = 0;
  logic [7:0]            tb_start_type = fpfd_pkg::START_TYPE_RESET;
  int unsigned           bytes_sent = 0;

  int                    idle_tbl [4] = '{0, 56, 0, 22};
  int                    stall_tbl [4] = '{0, 0, 56, 22};
  int unsigned           seg_len [12] = '{6, 3, 9, 0, 17, 6, 40, 5, 12, 300, 7, 23};

  fixed_packet_frame_deframer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_prior_cut      (out_prior_cut),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  fpfd_deframer_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_prior_cut      (out_prior_cut),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .words_outstanding  (words_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it, and wait for accept
  task automatic send_word(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    tb_pos = (tb_pos + 1 >= tb_pkt_len) ? 0 : tb_pos + 1;
  endtask

  // stop sending, wait for every expected word, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fpfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpfd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fpfd_pkg::REG_PACKET_LENGTH)
      tb_pkt_len = (val < fpfd_pkg::MIN_PKT_LEN) ? fpfd_pkg::MIN_PKT_LEN : val;
    else if (idx == fpfd_pkg::REG_START_TYPE)
      tb_start_type = val[fpfd_pkg::TYPE_W-1:0];
  endtask

  // well-formed frame: start packet, length header, continuations; some are
  // cut short by the next start, some carry surplus packets
  task automatic send_random_frame();
    logic [31:0] flen;
    int unsigned roll;
    int unsigned room;
    int unsigned npk;
    logic [7:0]  ctype;
    while (tb_pos != 0) send_word(8'($urandom_range(255)));
    roll = $urandom_range(99);
    if (roll < 8) flen = 0;
    else if (roll < 16) flen = 1;
    else if (roll < 22) flen = 32'hFF000000 | $urandom_range(16'hFFFF);
    else if (roll < 25) flen = '1;
    else flen = $urandom_range(2, 3 * tb_pkt_len);
    room = tb_pkt_len - 5;
    npk = 1;
    while (room < flen && (npk + 1) * tb_pkt_len < 200) begin
      room += tb_pkt_len - 1;
      npk++;
    end
    roll = $urandom_range(99);
    if (roll < 15) npk = $urandom_range(1, npk);
    else if (roll < 30) npk++;
    send_word(tb_start_type);
    send_word(flen[31:24]);
    send_word(flen[23:16]);
    send_word(flen[15:8]);
    send_word(flen[7:0]);
    repeat (tb_pkt_len - 5) send_word(8'($urandom_range(255)));
    repeat (npk - 1) begin
      ctype = 8'($urandom_range(255));
      if (ctype == tb_start_type) ctype = ctype + 8'd1;
      send_word(ctype);
      repeat (tb_pkt_len - 1) send_word(8'($urandom_range(255)));
    end
  endtask

  // random bytes: a whole packet or a fragment that shifts the alignment
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1) ? tb_pkt_len : $urandom_range(1, tb_pkt_len - 1);
    repeat (n) send_word(8'($urandom_range(255)));
  endtask

  initial begin
    int          seg;
    int unsigned target;
    logic [7:0]  st;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // before sync: non-start packet dropped, start code off position 0 is data
    send_word(8'h00); send_word(8'h01);
    wait_idle();
    // short length register acts as 6; pad out the current packet
    write_reg(fpfd_pkg::REG_PACKET_LENGTH, 16'd5);
    send_word(8'h02); send_word(8'h02); send_word(8'h02); send_word(8'h02);
    // two-byte frame, its continuation carries one surplus byte
    send_word(8'h01); send_word(8'h00); send_word(8'h00); send_word(8'h00);
    send_word(8'h02); send_word(8'hA5);
    send_word(8'h7E); send_word(8'h5A); send_word(8'hFF);
    wait_idle();
    // longest packets, start type with junk in the upper data bits, dead index
    write_reg(fpfd_pkg::REG_PACKET_LENGTH, 16'hFFFF);
    write_reg(fpfd_pkg::REG_START_TYPE, 16'hC3FF);
    write_reg(REG_NONE, 16'hFFFF);
    send_word(8'h11); send_word(8'h22);
    wait_idle();
    // shrink the length mid-packet: next byte wraps the position
    write_reg(fpfd_pkg::REG_PACKET_LENGTH, 16'd6);
    send_word(8'h33);
    // largest frame length, then a cut by an empty frame, then a short frame
    send_word(8'hFF); send_word(8'hFF); send_word(8'hFF); send_word(8'hFF);
    send_word(8'hFF); send_word(8'h00);
    send_word(8'hFF); send_word(8'h00); send_word(8'h00); send_word(8'h00);
    send_word(8'h00); send_word(8'h7F);
    send_word(8'hFF); send_word(8'h00); send_word(8'h00); send_word(8'h00);
    send_word(8'h01); send_word(8'hC3);

    // random frames over idling phases and register settings
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      for (int sg = 0; sg < 3; sg++) begin
        seg = ph * 3 + sg;
        wait_idle();
        write_reg(fpfd_pkg::REG_PACKET_LENGTH, fpfd_pkg::CFG_DATA_W'(seg_len[seg]));
        st = (seg == 0) ? 8'h00 : (seg == 1) ? 8'hFF : 8'($urandom_range(255));
        write_reg(fpfd_pkg::REG_START_TYPE, {8'($urandom_range(255)), st});
        if (seg == 1) hold_req = 1'b1;
        target = bytes_sent + SEG_WORDS;
        while (bytes_sent < target) begin
          if ($urandom_range(9) == 0) send_noise();
          else send_random_frame();
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
